>>> rtl/mh64_pkg.sv
// ----------------------------------------------------------------------------
// mh64_pkg
// Shared constants, types and helpers for the streaming 64-bit murmur-style
// hash block.
// ----------------------------------------------------------------------------
package mh64_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned CountW  = 4;
  localparam int unsigned LenW    = 25;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned HalfW   = WordW / 2;

  localparam logic [WordW-1:0] SEED_RESET   = 64'h0000_0000_adc8_3b19;
  localparam logic [LenW-1:0]  MAXLEN_RESET = LenW'(1024 * 1024);
  localparam logic [LenW-1:0]  LIMIT_CAP    = LenW'(16777216);

  localparam logic [WordW-1:0] C1    = 64'h87c3_7b91_1142_53d5;
  localparam logic [WordW-1:0] C2    = 64'h4cf5_b8ed_4417_4149;
  localparam logic [WordW-1:0] ADD_K = 64'h0000_0000_52dc_e729;
  localparam logic [WordW-1:0] FM1   = 64'hff51_afd7_ed55_8ccd;
  localparam logic [WordW-1:0] FM2   = 64'hc4ce_b9fe_1a85_ec53;

  localparam logic [CountW-1:0] FULL_BYTES = 4'd8;

  localparam logic [CfgIdxW-1:0] REG_HASH_SEED  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_MAX_LENGTH = 1'b1;

  typedef struct packed {
    logic [WordW-1:0] seed;
    logic [LenW-1:0]  limit;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] p;
  } mul_rsp_t;

  typedef enum logic [2:0] {
    MS_IDLE   = 3'b001,
    MS_CROSS1 = 3'b010,
    MS_CROSS2 = 3'b100
  } mstep_e;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MUL1 = 8'b0000_0010,
    ST_MUL2 = 8'b0000_0100,
    ST_MIX  = 8'b0000_1000,
    ST_FIN  = 8'b0001_0000,
    ST_FM1  = 8'b0010_0000,
    ST_FM2  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_e;

  function automatic logic [WordW-1:0] fold33(input logic [WordW-1:0] x);
    return x ^ (x >> 33);
  endfunction

endpackage

>>> rtl/mh64_mul.sv
// ----------------------------------------------------------------------------
// mh64_mul
// Iterative 64x64 multiplier keeping the low 64 bits of the product. One
// 32x32 multiplier is reused in turn: low x low, then the two
// cross terms shifted into the upper half.
// ----------------------------------------------------------------------------
module mh64_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mh64_pkg::mul_req_t req_i,
  output mh64_pkg::mul_rsp_t rsp_o
);
  import mh64_pkg::*;

  mstep_e           step_q, step_d;
  logic [WordW-1:0] a_q, a_d, b_q, b_d;
  logic [WordW-1:0] acc_q, acc_d;
  logic             done_q, done_d;
  logic [HalfW-1:0] opa, opb;
  logic [WordW-1:0] prod;

  always_comb begin
    unique case (step_q)
      MS_IDLE: begin
        opa = req_i.a[HalfW-1:0];
        opb = req_i.b[HalfW-1:0];
      end
      MS_CROSS1: begin
        opa = a_q[HalfW-1:0];
        opb = b_q[WordW-1:HalfW];
      end
      MS_CROSS2: begin
        opa = a_q[WordW-1:HalfW];
        opb = b_q[HalfW-1:0];
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod = WordW'(opa) * WordW'(opb);

  always_comb begin
    step_d = step_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    unique case (step_q)
      MS_IDLE: begin
        if (req_i.start) begin
          a_d    = req_i.a;
          b_d    = req_i.b;
          acc_d  = prod;
          step_d = MS_CROSS1;
        end
      end
      MS_CROSS1: begin
        acc_d  = acc_q + {prod[HalfW-1:0], {HalfW{1'b0}}};
        step_d = MS_CROSS2;
      end
      MS_CROSS2: begin
        acc_d  = acc_q + {prod[HalfW-1:0], {HalfW{1'b0}}};
        done_d = 1'b1;
        step_d = MS_IDLE;
      end
      default: begin
        step_d = MS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= MS_IDLE;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

endmodule

>>> rtl/mh64_core.sv
// ----------------------------------------------------------------------------
// mh64_core
// Word sequencer and hash datapath. Steps each word through the block mix
// and, for the last word, fmix64 via the shared multiplier, and keeps the
// running accumulator and byte count between words of a message.
// ----------------------------------------------------------------------------
module mh64_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mh64_pkg::cfg_t                       cfg_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [mh64_pkg::WordW-1:0]           data_word_i,
  input  logic [mh64_pkg::CountW-1:0]          byte_count_i,
  input  logic                                 last_item_i,
  input  logic                                 out_free_i,
  output logic                                 res_valid_o,
  output logic [mh64_pkg::WordW-1:0]           res_hash_o
);
  import mh64_pkg::*;

  state_e           state_q, state_d;
  logic [WordW-1:0] h_q, h_d;
  logic             full_q, full_d;
  logic             last_q, last_d;
  logic [LenW-1:0]  total_q, total_d;
  logic [LenW-1:0]  btot_q, btot_d;

  mul_req_t         mreq;
  mul_rsp_t         mrsp;

  logic             in_acc;
  logic [CountW-1:0] cnt_eff;
  logic [WordW-1:0] word_m;
  logic [WordW-1:0] h0;
  logic [LenW:0]    sum, cap, total_c;
  logic [WordW-1:0] kr, hx, hfin;

  mh64_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);

  // tail length; non-final words and counts above 8 count as full
  assign cnt_eff = (!last_item_i || byte_count_i > FULL_BYTES) ? FULL_BYTES : byte_count_i;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      word_m[8*b +: 8] = (CountW'(b) < cnt_eff) ? data_word_i[8*b +: 8] : 8'h00;
    end
  end

  assign h0      = (btot_q == '0) ? cfg_i.seed : h_q;
  assign sum     = {1'b0, btot_q} + (LenW+1)'(cnt_eff);
  assign cap     = {1'b0, cfg_i.limit} + (LenW+1)'(1);
  assign total_c = (sum > cap) ? cap : sum;

  assign kr   = {mrsp.p[32:0], mrsp.p[63:33]};
  assign hx   = h_q ^ mrsp.p;
  assign hfin = fold33(h_q ^ WordW'(total_q));

  always_comb begin
    state_d    = state_q;
    h_d        = h_q;
    full_d     = full_q;
    last_d     = last_q;
    total_d    = total_q;
    btot_d     = btot_q;
    mreq.start = 1'b0;
    mreq.a     = word_m;
    mreq.b     = C1;
    res_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          h_d     = h0;
          full_d  = (cnt_eff == FULL_BYTES);
          last_d  = last_item_i;
          total_d = total_c[LenW-1:0];
          btot_d  = last_item_i ? '0 : total_c[LenW-1:0];
          if (cnt_eff == '0) begin
            state_d = ST_FIN;
          end else begin
            mreq.start = 1'b1;
            state_d    = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        mreq.a = kr;
        mreq.b = C2;
        if (mrsp.done) begin
          mreq.start = 1'b1;
          state_d    = ST_MUL2;
        end
      end
      ST_MUL2: begin
        if (mrsp.done) begin
          if (full_q) begin
            h_d     = {hx[36:0], hx[63:37]} + cfg_i.seed;
            state_d = ST_MIX;
          end else begin
            h_d     = hx;
            state_d = ST_FIN;
          end
        end
      end
      ST_MIX: begin
        h_d     = {h_q[WordW-3:0], 2'b00} + h_q + ADD_K;
        state_d = last_q ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        mreq.a = hfin;
        mreq.b = FM1;
        if (total_q > cfg_i.limit) begin
          h_d     = '0;
          state_d = ST_DONE;
        end else begin
          mreq.start = 1'b1;
          state_d    = ST_FM1;
        end
      end
      ST_FM1: begin
        mreq.a = fold33(mrsp.p);
        mreq.b = FM2;
        if (mrsp.done) begin
          mreq.start = 1'b1;
          state_d    = ST_FM2;
        end
      end
      ST_FM2: begin
        if (mrsp.done) begin
          h_d     = fold33(mrsp.p);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_hash_o = h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      btot_q  <= '0;
      full_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      btot_q  <= btot_d;
      full_q  <= full_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q     <= h_d;
    total_q <= total_d;
  end

endmodule

>>> rtl/murmur_style_hash64.sv
// ----------------------------------------------------------------------------
// murmur_style_hash64
// Streaming single-lane murmur-style 64-bit hash with a length limit.
// ----------------------------------------------------------------------------
// Words of a message arrive little-endian, eight bytes each; the last word
// carries 0 to 8 valid bytes and produces one hash word on the output. All
// 64-bit products go through one shared multiplier built around a single
// 32x32 multiplier. A non-final word passes both block products and the
// mix; the last word also gets both fmix products, a 1-7 byte tail skips
// the mix, an empty one has only the fmix, and an overlong message gets
// zero without it. The input is stalled while a word is in work. A finished
// hash sits in an output register, so the next message can start while it
// waits to be taken. Config writes are expected only while idle.
module murmur_style_hash64 (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mh64_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [mh64_pkg::WordW-1:0]       cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [mh64_pkg::WordW-1:0]       data_word_i,
  input  logic [mh64_pkg::CountW-1:0]      byte_count_i,
  input  logic                             last_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [mh64_pkg::WordW-1:0]       hash_value_o
);
  import mh64_pkg::*;

  logic [WordW-1:0] seed_q, seed_d;
  logic [LenW-1:0]  maxlen_q, maxlen_d;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] hash_q, hash_d;
  cfg_t             cfg;
  logic             out_free;
  logic             res_valid;
  logic [WordW-1:0] res_hash;

  always_comb begin
    seed_d   = seed_q;
    maxlen_d = maxlen_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HASH_SEED:  seed_d   = cfg_wdata_i;
        REG_MAX_LENGTH: maxlen_d = cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.seed  = seed_q;
  assign cfg.limit = (maxlen_q > LIMIT_CAP) ? LIMIT_CAP : maxlen_q;

  assign out_free = !out_valid_q || !out_stall_i;

  mh64_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_item_i  (last_item_i),
    .out_free_i   (out_free),
    .res_valid_o  (res_valid),
    .res_hash_o   (res_hash)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    hash_d      = hash_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      hash_d      = res_hash;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= SEED_RESET;
      maxlen_q    <= MAXLEN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      seed_q      <= seed_d;
      maxlen_q    <= maxlen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

endmodule

>>> rtl/mh64_chk.sv
// ----------------------------------------------------------------------------
// mh64_chk
// Port-level checks for the hash block, bound to the top level.
// ----------------------------------------------------------------------------
module mh64_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic [mh64_pkg::WordW-1:0]       data_word_i,
  input logic [mh64_pkg::CountW-1:0]      byte_count_i,
  input logic                             last_item_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [mh64_pkg::WordW-1:0]       hash_value_o
);

  // a stalled result word stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(hash_value_o))
    else $error("result word changed while stalled");

  // a stalled input word stays
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(data_word_i) &&
    $stable(byte_count_i) && $stable(last_item_i))
    else $error("input word changed while stalled");

  // an accepted word stalls the input in the following cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a word");

  // a word that is not last never yields a result right away
  a_no_result_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !last_item_i |=> !$rose(out_valid_o))
    else $error("result raised by a non-final word");

endmodule

bind murmur_style_hash64 mh64_chk u_mh64_chk (.*);
